// ===== rtl/core/tifn_pkg.sv =====
// tifn_pkg: shared types and constants of the telnet iac filter and negotiator
// no dependencies; used by every module under rtl/core
`default_nettype none

package tifn_pkg;

    // telnet command bytes
    localparam logic [7:0] TN_IAC  = 8'hFF;
    localparam logic [7:0] TN_SB   = 8'hFA;
    localparam logic [7:0] TN_SE   = 8'hF0;
    localparam logic [7:0] TN_WILL = 8'hFB;
    localparam logic [7:0] TN_WONT = 8'hFC;
    localparam logic [7:0] TN_DO   = 8'hFD;
    localparam logic [7:0] TN_DONT = 8'hFE;

    // telnet options
    localparam logic [7:0] OPT_BINARY = 8'h00;
    localparam logic [7:0] OPT_ECHO   = 8'h01;
    localparam logic [7:0] OPT_SGA    = 8'h03;
    localparam logic [7:0] OPT_TTYPE  = 8'h18;
    localparam logic [7:0] OPT_NAWS   = 8'h1F;

    // pending verb, coded as verb minus WILL
    localparam logic [1:0] VERB_WILL = 2'd0;
    localparam logic [1:0] VERB_DO   = 2'd2;

    // input word kinds
    localparam logic [1:0] ACT_LINK  = 2'd0;
    localparam logic [1:0] ACT_SEND  = 2'd1;
    localparam logic [1:0] ACT_RESET = 2'd2;

    // output destinations
    localparam logic [1:0] DEST_TERM = 2'd0;
    localparam logic [1:0] DEST_LINK = 2'd1;
    localparam logic [1:0] DEST_DISC = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_COLS = 2'd0;
    localparam logic [1:0] REG_ROWS = 2'd1;
    localparam logic [1:0] REG_ANSI = 2'd2;

    // job queue between parser and expander
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    typedef enum logic [2:0] {
        PH_DATA    = 3'd0,
        PH_IAC     = 3'd1,
        PH_OPT     = 3'd2,
        PH_SB_OPT  = 3'd3,
        PH_SB_DATA = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        JOB_TERM   = 3'd0,  // one byte to terminal
        JOB_LINK1  = 3'd1,  // one byte to link
        JOB_LINK2  = 3'd2,  // doubled iac to link
        JOB_REPLY  = 3'd3,  // iac, verb, option
        JOB_NAWS   = 3'd4,  // will naws plus window size subneg
        JOB_TTYPE  = 3'd5,  // terminal type answer
        JOB_DISC   = 3'd6   // disconnect request
    } t_job_kind;

    typedef struct packed {
        t_job_kind  kind;
        logic [7:0] b0;
        logic [7:0] b1;
    } t_job;

    typedef struct packed {
        logic [1:0] dest;
        logic [7:0] data;
        logic       last;
    } t_beat;

endpackage

`default_nettype wire

// ===== rtl/core/tifn_front.sv =====
// tifn_front: telnet parser, turns accepted input words into output jobs
// depends on tifn_pkg
`default_nettype none

module tifn_front #(
    parameter int SUBNEG_LIMIT = 4096
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_accept,
    input  wire  [1:0]        i_action,
    input  wire  [7:0]        i_byte,
    output logic              o_push,
    output tifn_pkg::t_job    o_job
);

    localparam int CW = $clog2(SUBNEG_LIMIT + 1);

    tifn_pkg::t_phase r_phase, n_phase;
    logic [1:0]       r_verb, n_verb;
    logic [7:0]       r_sb_opt, n_sb_opt;
    logic             r_prev_iac, n_prev_iac;
    logic [CW-1:0]    r_count, n_count;
    logic             r_seen, n_seen;

    logic [CW-1:0]    w_cnt_inc;
    logic             w_sb_end;
    logic             w_overrun;

    assign w_cnt_inc = r_count + CW'(1);
    assign w_sb_end  = r_prev_iac && (i_byte == tifn_pkg::TN_SE);
    assign w_overrun = (w_cnt_inc >= CW'(SUBNEG_LIMIT));

    // next state
    always_comb begin
        n_phase    = r_phase;
        n_verb     = r_verb;
        n_sb_opt   = r_sb_opt;
        n_prev_iac = r_prev_iac;
        n_count    = r_count;
        n_seen     = r_seen;
        if (i_accept) begin
            case (i_action)
                tifn_pkg::ACT_LINK: begin
                    case (r_phase)
                        tifn_pkg::PH_DATA: begin
                            if (i_byte == tifn_pkg::TN_IAC) begin
                                n_seen  = 1'b1;
                                n_phase = tifn_pkg::PH_IAC;
                            end
                        end
                        tifn_pkg::PH_IAC: begin
                            if (i_byte inside {[tifn_pkg::TN_WILL:tifn_pkg::TN_DONT]}) begin
                                n_verb  = 2'(i_byte - tifn_pkg::TN_WILL);
                                n_phase = tifn_pkg::PH_OPT;
                            end else if (i_byte == tifn_pkg::TN_SB) begin
                                n_phase = tifn_pkg::PH_SB_OPT;
                            end else begin
                                n_phase = tifn_pkg::PH_DATA;
                            end
                        end
                        tifn_pkg::PH_OPT: begin
                            n_phase = tifn_pkg::PH_DATA;
                        end
                        tifn_pkg::PH_SB_OPT: begin
                            n_sb_opt   = i_byte;
                            n_prev_iac = 1'b0;
                            n_count    = '0;
                            n_phase    = tifn_pkg::PH_SB_DATA;
                        end
                        tifn_pkg::PH_SB_DATA: begin
                            if (w_sb_end) begin
                                n_phase = tifn_pkg::PH_DATA;
                            end else if (w_overrun) begin
                                n_phase    = tifn_pkg::PH_DATA;
                                n_verb     = '0;
                                n_sb_opt   = '0;
                                n_prev_iac = 1'b0;
                                n_count    = '0;
                                n_seen     = 1'b0;
                            end else begin
                                n_prev_iac = (i_byte == tifn_pkg::TN_IAC);
                                n_count    = w_cnt_inc;
                            end
                        end
                        default: begin
                            n_phase = tifn_pkg::PH_DATA;
                        end
                    endcase
                end
                tifn_pkg::ACT_RESET: begin
                    n_phase    = tifn_pkg::PH_DATA;
                    n_verb     = '0;
                    n_sb_opt   = '0;
                    n_prev_iac = 1'b0;
                    n_count    = '0;
                    n_seen     = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    // job output
    always_comb begin
        o_push   = 1'b0;
        o_job.kind = tifn_pkg::JOB_TERM;
        o_job.b0 = i_byte;
        o_job.b1 = i_byte;
        if (i_accept) begin
            case (i_action)
                tifn_pkg::ACT_LINK: begin
                    case (r_phase)
                        tifn_pkg::PH_DATA: begin
                            o_push = (i_byte != tifn_pkg::TN_IAC);
                        end
                        tifn_pkg::PH_IAC: begin
                            o_push = (i_byte == tifn_pkg::TN_IAC);
                        end
                        tifn_pkg::PH_OPT: begin
                            if (r_verb == tifn_pkg::VERB_DO) begin
                                o_push = 1'b1;
                                if (i_byte == tifn_pkg::OPT_NAWS) begin
                                    o_job.kind = tifn_pkg::JOB_NAWS;
                                end else begin
                                    o_job.kind = tifn_pkg::JOB_REPLY;
                                    o_job.b0 = (i_byte == tifn_pkg::OPT_BINARY ||
                                                i_byte == tifn_pkg::OPT_TTYPE) ?
                                               tifn_pkg::TN_WILL : tifn_pkg::TN_WONT;
                                end
                            end else if (r_verb == tifn_pkg::VERB_WILL) begin
                                o_push     = 1'b1;
                                o_job.kind = tifn_pkg::JOB_REPLY;
                                o_job.b0   = (i_byte == tifn_pkg::OPT_ECHO ||
                                              i_byte == tifn_pkg::OPT_SGA) ?
                                             tifn_pkg::TN_DO : tifn_pkg::TN_DONT;
                            end
                        end
                        tifn_pkg::PH_SB_DATA: begin
                            if (w_sb_end) begin
                                o_push     = (r_sb_opt == tifn_pkg::OPT_TTYPE);
                                o_job.kind = tifn_pkg::JOB_TTYPE;
                            end else if (w_overrun) begin
                                o_push     = 1'b1;
                                o_job.kind = tifn_pkg::JOB_DISC;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                tifn_pkg::ACT_SEND: begin
                    o_push     = 1'b1;
                    o_job.kind = (i_byte == tifn_pkg::TN_IAC && r_seen) ?
                                 tifn_pkg::JOB_LINK2 : tifn_pkg::JOB_LINK1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= tifn_pkg::PH_DATA;
            r_verb     <= '0;
            r_sb_opt   <= '0;
            r_prev_iac <= 1'b0;
            r_count    <= '0;
            r_seen     <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_verb     <= n_verb;
            r_sb_opt   <= n_sb_opt;
            r_prev_iac <= n_prev_iac;
            r_count    <= n_count;
            r_seen     <= n_seen;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/tifn_queue.sv =====
// tifn_queue: short job queue between parser and expander
// depends on tifn_pkg
`default_nettype none

module tifn_queue (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_push,
    input  tifn_pkg::t_job    i_job,
    input  wire               i_pop,
    output logic              o_full,
    output logic              o_nonempty,
    output tifn_pkg::t_job    o_head
);

    tifn_pkg::t_job                 r_mem [tifn_pkg::QUEUE_DEPTH];
    logic [tifn_pkg::QPTR_W-1:0]    r_wr_ptr, r_rd_ptr;
    logic [tifn_pkg::QPTR_W:0]      r_count;

    assign o_full     = (r_count == (tifn_pkg::QPTR_W + 1)'(tifn_pkg::QUEUE_DEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_head     = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/tifn_back.sv =====
// tifn_back: expands queued jobs into output words, one per cycle while a job waits and the receiver is ready
// depends on tifn_pkg
`default_nettype none

module tifn_back (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_nonempty,
    input  tifn_pkg::t_job    i_head,
    output logic              o_pop,
    input  wire  [7:0]        i_columns,
    input  wire  [7:0]        i_rows,
    input  wire               i_ansi,
    output logic              o_tvalid,
    input  wire               i_tready,
    output logic [7:0]        o_tdata,
    output logic [1:0]        o_tuser,
    output logic              o_tlast
);

    logic [3:0]        r_idx;
    logic              r_valid;
    logic [7:0]        r_data;
    logic [1:0]        r_user;
    logic              r_last;
    logic              w_load;
    tifn_pkg::t_beat   w_beat;

    // word number idx of a job
    function automatic tifn_pkg::t_beat job_beat(
        input tifn_pkg::t_job j,
        input logic [3:0]     idx,
        input logic [7:0]     cols,
        input logic [7:0]     rows,
        input logic           ansi
    );
        tifn_pkg::t_beat b;
        b.dest = tifn_pkg::DEST_LINK;
        b.data = tifn_pkg::TN_IAC;
        b.last = 1'b0;
        case (j.kind)
            tifn_pkg::JOB_TERM: begin
                b.dest = tifn_pkg::DEST_TERM;
                b.data = j.b0;
                b.last = 1'b1;
            end
            tifn_pkg::JOB_LINK1: begin
                b.data = j.b0;
                b.last = 1'b1;
            end
            tifn_pkg::JOB_LINK2: begin
                b.last = (idx == 4'd1);
            end
            tifn_pkg::JOB_REPLY: begin
                case (idx)
                    4'd0:    b.data = tifn_pkg::TN_IAC;
                    4'd1:    b.data = j.b0;
                    default: b.data = j.b1;
                endcase
                b.last = (idx == 4'd2);
            end
            tifn_pkg::JOB_NAWS: begin
                case (idx)
                    4'd0:    b.data = tifn_pkg::TN_IAC;
                    4'd1:    b.data = tifn_pkg::TN_WILL;
                    4'd2:    b.data = tifn_pkg::OPT_NAWS;
                    4'd3:    b.data = tifn_pkg::TN_IAC;
                    4'd4:    b.data = tifn_pkg::TN_SB;
                    4'd5:    b.data = tifn_pkg::OPT_NAWS;
                    4'd6:    b.data = 8'h00;
                    4'd7:    b.data = cols;
                    4'd8:    b.data = 8'h00;
                    4'd9:    b.data = rows;
                    4'd10:   b.data = tifn_pkg::TN_IAC;
                    default: b.data = tifn_pkg::TN_SE;
                endcase
                b.last = (idx == 4'd11);
            end
            tifn_pkg::JOB_TTYPE: begin
                case (idx)
                    4'd0:    b.data = tifn_pkg::TN_IAC;
                    4'd1:    b.data = tifn_pkg::TN_SB;
                    4'd2:    b.data = tifn_pkg::OPT_TTYPE;
                    4'd3:    b.data = 8'h00;
                    4'd4:    b.data = ansi ? "A" : "C";
                    4'd5:    b.data = ansi ? "N" : "B";
                    4'd6:    b.data = ansi ? "S" : "M";
                    4'd7:    b.data = ansi ? "I" : tifn_pkg::TN_IAC;
                    4'd8:    b.data = ansi ? tifn_pkg::TN_IAC : tifn_pkg::TN_SE;
                    default: b.data = tifn_pkg::TN_SE;
                endcase
                b.last = ansi ? (idx == 4'd9) : (idx == 4'd8);
            end
            tifn_pkg::JOB_DISC: begin
                b.dest = tifn_pkg::DEST_DISC;
                b.data = 8'h00;
                b.last = 1'b1;
            end
            default: begin
                b.last = 1'b1;
            end
        endcase
        return b;
    endfunction

    assign w_beat   = job_beat(i_head, r_idx, i_columns, i_rows, i_ansi);
    assign w_load   = i_nonempty && (!r_valid || i_tready);
    assign o_pop    = w_load && w_beat.last;
    assign o_tvalid = r_valid;
    assign o_tdata  = r_data;
    assign o_tuser  = r_user;
    assign o_tlast  = r_last;

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_data <= w_beat.data;
            r_user <= w_beat.dest;
            r_last <= w_beat.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (w_load) begin
                r_valid <= 1'b1;
                r_idx   <= w_beat.last ? 4'd0 : r_idx + 4'd1;
            end else if (i_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/telnet_iac_filter_negotiator.sv =====
// telnet_iac_filter_negotiator: top level, config registers and the three stages
// depends on tifn_pkg, tifn_front, tifn_queue, tifn_back
//
// usage
//   slave stream: tuser carries the action (link byte, outgoing byte, session reset),
//   tdata carries the byte. the parser takes a word in every cycle the job queue has
//   room; a word that gives results becomes one job in a four-entry queue.
//   master stream: tuser is the destination (terminal, link, disconnect), tdata the
//   byte, tlast marks the final word caused by one input word.
//   a taken input word's job is registered in the queue, then its first result word
//   in the output register. throughput: one input word per cycle while each word
//   gives at most one result; a job of n result words holds the expander until all n
//   are sent (up to 12 for a window size reply), and the queue absorbs such bursts
//   before the input backs up. a receiver stall holds the output register; the queue
//   then fills and tready drops. reset clears the parser, queue and output register
//   and loads the config registers with 40 columns, 25 rows and the cbm terminal type.
//   config writes take effect at once and are meant to happen while idle.
`default_nettype none

module telnet_iac_filter_negotiator #(
    parameter int SUBNEG_LIMIT = 4096
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // slave stream
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [7:0]  i_s_axis_tdata,    // [7:0] byte_in
    input  wire  [1:0]  i_s_axis_tuser,    // [1:0] action
    // master stream
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,    // [7:0] byte_out
    output logic [1:0]  o_m_axis_tuser,    // [1:0] destination
    output logic        o_m_axis_tlast,
    // config write port
    input  wire         i_cfg_we,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [7:0]  i_cfg_data
);

    logic [7:0]       r_columns;
    logic [7:0]       r_rows;
    logic             r_ansi;

    logic             w_full;
    logic             w_accept;
    logic             w_push;
    logic             w_pop;
    logic             w_nonempty;
    tifn_pkg::t_job   w_job;
    tifn_pkg::t_job   w_head;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_columns <= 8'd40;
            r_rows    <= 8'd25;
            r_ansi    <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tifn_pkg::REG_COLS: r_columns <= i_cfg_data;
                tifn_pkg::REG_ROWS: r_rows    <= i_cfg_data;
                tifn_pkg::REG_ANSI: r_ansi    <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // take a word whenever the queue can hold its job
    assign o_s_axis_tready = !w_full;
    assign w_accept        = i_s_axis_tvalid && !w_full;

    tifn_front #(
        .SUBNEG_LIMIT (SUBNEG_LIMIT)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_action (i_s_axis_tuser),
        .i_byte   (i_s_axis_tdata),
        .o_push   (w_push),
        .o_job    (w_job)
    );

    tifn_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_job      (w_job),
        .i_pop      (w_pop),
        .o_full     (w_full),
        .o_nonempty (w_nonempty),
        .o_head     (w_head)
    );

    tifn_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_nonempty (w_nonempty),
        .i_head     (w_head),
        .o_pop      (w_pop),
        .i_columns  (r_columns),
        .i_rows     (r_rows),
        .i_ansi     (r_ansi),
        .o_tvalid   (o_m_axis_tvalid),
        .i_tready   (i_m_axis_tready),
        .o_tdata    (o_m_axis_tdata),
        .o_tuser    (o_m_axis_tuser),
        .o_tlast    (o_m_axis_tlast)
    );

endmodule

`default_nettype wire
